>>> hdl/llrb_pkg.sv
// ----------------------------------------------------------------------------
// llrb_pkg: shared definitions for the last-lines ring buffer
// Sizes of the line store, command and state codes, and the reset value of
// the line-count register.
// ----------------------------------------------------------------------------
package llrb_pkg;

   // Store geometry.
   localparam int MAX_LINES  = 128;
   localparam int LINE_BYTES = 256;

   // Derived widths: slot index, byte offset within a slot, store address.
   localparam int SLOT_W    = $clog2(MAX_LINES);
   localparam int OFS_W     = $clog2(LINE_BYTES);
   localparam int ADDR_W    = SLOT_W + OFS_W;
   localparam int MEM_DEPTH = MAX_LINES << OFS_W;

   // Line-count register and the width of counts that compare against it.
   localparam int KEPT_W = 8;
   localparam int CNT_W  = (SLOT_W + 1 > KEPT_W) ? SLOT_W + 1 : KEPT_W;
   localparam logic [KEPT_W-1:0] KEPT_DEFAULT = KEPT_W'(10);

   // Stream payload widths.
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 2;
   localparam logic [BYTE_W-1:0] NEWLINE = BYTE_W'(10);

   // Commands carried in the request tuser field.
   typedef enum logic [CMD_W-1:0] {
      CMD_BYTE = 2'd0,
      CMD_END  = 2'd1,
      CMD_PULL = 2'd2
   } cmd_type;

   // Control states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

endpackage

>>> hdl/last_lines_ring_buffer.sv
// ----------------------------------------------------------------------------
// last_lines_ring_buffer: keeps the most recent lines of a byte stream
// A pull reads the store into read registers, then ST_READ loads the result register.
// Throughput: one byte or end item per cycle while idle; no request is taken in ST_READ.
// Reset clears all counters and sets lines_kept to 10; stores are not cleared.
// ----------------------------------------------------------------------------
module last_lines_ring_buffer (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] out_valid
   output logic        rsp_tlast,   // out_last
   // Configuration.
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata    // lines_kept
);

   localparam int SLOT_W = llrb_pkg::SLOT_W;
   localparam int OFS_W  = llrb_pkg::OFS_W;
   localparam int CNT_W  = llrb_pkg::CNT_W;

   // Storage: line bytes and the length of each slot.
   logic [llrb_pkg::BYTE_W-1:0] line_store [llrb_pkg::MEM_DEPTH];
   logic [OFS_W-1:0]            slot_len   [llrb_pkg::MAX_LINES];

   // Control state.
   llrb_pkg::state_type          state_ff, state_in;
   logic [llrb_pkg::KEPT_W-1:0]  kept_ff, kept_in;
   logic [SLOT_W-1:0]            ws_ff, ws_in;
   logic [OFS_W-1:0]             cur_len_ff, cur_len_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [SLOT_W-1:0]            rs_ff, rs_in;
   logic [OFS_W-1:0]             ro_ff, ro_in;
   logic [CNT_W-1:0]             ll_ff, ll_in;
   logic                         drain_ff, drain_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Read data and payload registers.
   logic                         hit_ff;
   logic [llrb_pkg::BYTE_W-1:0]  rd_byte_ff;
   logic [OFS_W-1:0]             rd_len_ff;
   logic [llrb_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                         rsp_flag_ff;
   logic                         rsp_last_ff;

   // Combinational helpers.
   logic [CNT_W-1:0]  k;
   logic              accept;
   logic              is_byte, is_end, is_pull;
   logic [OFS_W-1:0]  len_inc;
   logic              close_byte, close_line;
   logic [OFS_W-1:0]  close_len;
   logic [SLOT_W-1:0] ws_nx;
   logic [CNT_W-1:0]  cnt_sat;
   logic [SLOT_W-1:0] ws_e;
   logic [CNT_W-1:0]  cnt_e;
   logic [CNT_W:0]    rs_sum;
   logic [CNT_W:0]    rs_start;
   logic [OFS_W:0]    ro_inc;
   logic              wrap;
   logic [SLOT_W-1:0] rs_nx;
   logic              load;

   // Effective line count: zero acts as one, large values clip to the store size.
   always_comb begin
      if (kept_ff == '0) begin
         k = CNT_W'(1);
      end else if (CNT_W'(kept_ff) > CNT_W'(llrb_pkg::MAX_LINES)) begin
         k = CNT_W'(llrb_pkg::MAX_LINES);
      end else begin
         k = CNT_W'(kept_ff);
      end
   end

   // Request decode.
   assign req_tready = (state_ff == llrb_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   always_comb begin
      is_byte = 1'b0;
      is_end  = 1'b0;
      is_pull = 1'b0;
      if (accept) begin
         case (req_tuser)
            llrb_pkg::CMD_BYTE: is_byte = !drain_ff;
            llrb_pkg::CMD_END:  is_end  = !drain_ff;
            llrb_pkg::CMD_PULL: is_pull = 1'b1;
            default:            is_pull = 1'b0;
         endcase
      end
   end

   // Line closing: on a newline, at the length limit, or on end with a partial line.
   assign len_inc    = cur_len_ff + OFS_W'(1);
   assign close_byte = is_byte && ((req_tdata == llrb_pkg::NEWLINE) ||
                       ({1'b0, len_inc} >= (OFS_W+1)'(llrb_pkg::LINE_BYTES - 1)));
   assign close_line = close_byte || (is_end && (cur_len_ff != '0));
   assign close_len  = is_byte ? len_inc : cur_len_ff;
   assign ws_nx      = (CNT_W'(ws_ff) + CNT_W'(1) >= k) ? '0 : ws_ff + SLOT_W'(1);
   assign cnt_sat    = (cnt_ff < k) ? cnt_ff + CNT_W'(1) : k;

   // Oldest kept slot at end of input: (write slot + k - count) mod k.
   assign ws_e     = close_line ? ws_nx : ws_ff;
   assign cnt_e    = close_line ? cnt_sat : cnt_ff;
   assign rs_sum   = (CNT_W+1)'(ws_e) + {1'b0, k} - {1'b0, cnt_e};
   assign rs_start = (rs_sum >= {1'b0, k}) ? rs_sum - {1'b0, k} : rs_sum;

   // Read step: advance the offset, move to the next slot at the end of a line.
   assign ro_inc = {1'b0, ro_ff} + (OFS_W+1)'(1);
   assign wrap   = ro_inc >= {1'b0, rd_len_ff};
   assign rs_nx  = (CNT_W'(rs_ff) + CNT_W'(1) >= k) ? '0 : rs_ff + SLOT_W'(1);
   assign load   = (state_ff == llrb_pkg::ST_READ) && (!rsp_valid_ff || rsp_tready);

   // Next state of the control registers.
   always_comb begin
      state_in     = state_ff;
      kept_in      = kept_ff;
      ws_in        = ws_ff;
      cur_len_in   = cur_len_ff;
      cnt_in       = cnt_ff;
      rs_in        = rs_ff;
      ro_in        = ro_ff;
      ll_in        = ll_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         llrb_pkg::ST_IDLE: begin
            if (is_pull) begin
               state_in = llrb_pkg::ST_READ;
            end
         end
         llrb_pkg::ST_READ: begin
            if (load) begin
               state_in = llrb_pkg::ST_IDLE;
            end
         end
         default: state_in = llrb_pkg::ST_IDLE;
      endcase

      // Collecting: bytes fill the current slot.
      if (is_byte) begin
         cur_len_in = close_byte ? '0 : len_inc;
      end
      if (close_line) begin
         ws_in  = ws_nx;
         cnt_in = cnt_sat;
      end

      // End of input: set up the read pointers and switch to draining.
      if (is_end) begin
         cur_len_in = '0;
         ll_in      = cnt_e;
         rs_in      = SLOT_W'(rs_start);
         ro_in      = '0;
         drain_in   = 1'b1;
      end

      // Pull result: step the read pointers when a byte was delivered.
      if (load) begin
         rsp_valid_in = 1'b1;
         if (hit_ff) begin
            if (wrap) begin
               ro_in = '0;
               rs_in = rs_nx;
               ll_in = ll_ff - CNT_W'(1);
            end else begin
               ro_in = ro_inc[OFS_W-1:0];
            end
         end
      end

      // A register write drops all lines and returns to collecting.
      if (csr_wen) begin
         kept_in    = csr_wdata;
         ws_in      = '0;
         cur_len_in = '0;
         cnt_in     = '0;
         rs_in      = '0;
         ro_in      = '0;
         ll_in      = '0;
         drain_in   = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llrb_pkg::ST_IDLE;
         kept_ff      <= llrb_pkg::KEPT_DEFAULT;
         ws_ff        <= '0;
         cur_len_ff   <= '0;
         cnt_ff       <= '0;
         rs_ff        <= '0;
         ro_ff        <= '0;
         ll_ff        <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         ws_ff        <= ws_in;
         cur_len_ff   <= cur_len_in;
         cnt_ff       <= cnt_in;
         rs_ff        <= rs_in;
         ro_ff        <= ro_in;
         ll_ff        <= ll_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Line store: written while collecting, read on a pull.
   always_ff @(posedge clock) begin
      if (is_byte) begin
         line_store[{ws_ff, cur_len_ff}] <= req_tdata;
      end
      if (is_pull) begin
         rd_byte_ff <= line_store[{rs_ff, ro_ff}];
      end
   end

   // Slot lengths: written when a line closes, read on a pull.
   always_ff @(posedge clock) begin
      if (close_line) begin
         slot_len[ws_ff] <= close_len;
      end
      if (is_pull) begin
         rd_len_ff <= slot_len[rs_ff];
         hit_ff    <= drain_ff && (ll_ff != '0);
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= hit_ff ? rd_byte_ff : '0;
         rsp_flag_ff <= hit_ff;
         rsp_last_ff <= hit_ff && wrap && (ll_ff == CNT_W'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for last_lines_ring_buffer
// Streams bytes, end and pull items into the buffer and keeps its own copy of
// the line ring to predict every pull result. Covers the line-count extremes,
// forced line splits, pulls and stray items in each mode, a long output stall
// and randomly shaped line sets. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb;

   // Command code with no meaning in the block; it must be dropped.
   localparam logic [llrb_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

   localparam int RANDOM_ITEMS     = 300;
   localparam int MAX_GAP          = 15;
   localparam int SETTLE_CYCLES    = 8;
   localparam int STALL_CYCLES     = 300;
   localparam int SHOWN_MISMATCHES = 10;

   // One pull result: character, data-present flag, end-of-dump flag.
   typedef struct packed {
      logic [llrb_pkg::BYTE_W-1:0] char_out;
      logic                        has_data;
      logic                        is_last;
   } tail_rsp_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;   // [7:0] data_byte
   logic [1:0]        req_tuser;   // [1:0] cmd
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;   // [7:0] out_byte
   logic              rsp_tuser;   // [0] out_valid
   logic              rsp_tlast;   // out_last
   logic              csr_wen;
   logic [7:0]        csr_wdata;   // lines_kept

   // Predicted state of the line ring.
   logic [llrb_pkg::BYTE_W-1:0] line_mem [llrb_pkg::MEM_DEPTH];
   int                          slot_len [llrb_pkg::MAX_LINES];
   logic [llrb_pkg::KEPT_W-1:0] kept_reg   = llrb_pkg::KEPT_DEFAULT;
   int                          wr_slot    = 0;
   int                          fill_len   = 0;
   int                          line_total = 0;
   int                          rd_slot    = 0;
   int                          rd_pos     = 0;
   int                          lines_due  = 0;
   bit                          draining   = 1'b0;

   // Pull results still owed by the block, oldest first.
   tail_rsp_type      expected_rsp [$];

   // Handshake pacing.
   bit                req_idle_on   = 1'b1;
   bit                rsp_idle_on   = 1'b1;
   int                rsp_wait      = 0;
   int                rsp_hold      = 0;
   int                stall_asked   = 0;
   int                stall_done    = 0;
   int                results_paced = 0;

   // Run statistics.
   int                mismatches    = 0;
   int                results_seen  = 0;
   int                items_done    = 0;
   int                ignored_items = 0;
   int                config_writes = 0;

   last_lines_ring_buffer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   // Line count in effect: zero acts as one, large values clamp to the ring size.
   function automatic int kept_lines();
      if (kept_reg == '0) return 1;
      if (int'(kept_reg) > llrb_pkg::MAX_LINES) return llrb_pkg::MAX_LINES;
      return int'(kept_reg);
   endfunction

   function automatic int slot_after(int slot, int kept);
      return (slot + 1 >= kept) ? 0 : slot + 1;
   endfunction

   // Seal the line being filled and advance to the next slot.
   function automatic void seal_line();
      int kept;
      kept = kept_lines();
      slot_len[wr_slot] = fill_len;
      wr_slot = slot_after(wr_slot, kept);
      if (line_total < kept) line_total++;
      fill_len = 0;
   endfunction

   // Apply one accepted item to the predicted ring and work out its result.
   function automatic void tail_apply(input logic [llrb_pkg::CMD_W-1:0] cmd,
                                      input logic [llrb_pkg::BYTE_W-1:0] din,
                                      output bit has_rsp, output bit ignored,
                                      output tail_rsp_type rsp);
      int kept;
      kept    = kept_lines();
      has_rsp = 1'b0;
      ignored = 1'b0;
      rsp     = '0;
      case (cmd)
         llrb_pkg::CMD_BYTE: begin
            if (draining) begin
               ignored = 1'b1;
            end else begin
               line_mem[wr_slot * llrb_pkg::LINE_BYTES + fill_len] = din;
               fill_len++;
               if (din == llrb_pkg::NEWLINE || fill_len >= llrb_pkg::LINE_BYTES - 1)
                  seal_line();
            end
         end
         llrb_pkg::CMD_END: begin
            if (draining) begin
               ignored = 1'b1;
            end else begin
               if (fill_len > 0) seal_line();
               lines_due = (line_total < kept) ? line_total : kept;
               rd_slot   = (wr_slot + kept - lines_due) % kept;
               rd_pos    = 0;
               draining  = 1'b1;
            end
         end
         llrb_pkg::CMD_PULL: begin
            has_rsp = 1'b1;
            if (draining && lines_due != 0) begin
               rsp.char_out = line_mem[rd_slot * llrb_pkg::LINE_BYTES + rd_pos];
               rsp.has_data = 1'b1;
               rd_pos++;
               if (rd_pos >= slot_len[rd_slot]) begin
                  rd_pos  = 0;
                  rd_slot = slot_after(rd_slot, kept);
                  lines_due--;
                  if (lines_due == 0) rsp.is_last = 1'b1;
               end
            end
         end
         default: begin
            ignored = 1'b1;
         end
      endcase
   endfunction

   // Offer one item after a random gap and record it once it is accepted.
   task automatic send_item(logic [llrb_pkg::CMD_W-1:0] cmd,
                            logic [llrb_pkg::BYTE_W-1:0] din);
      int           gap;
      bit           has_rsp;
      bit           ignored;
      tail_rsp_type rsp;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= din;
      do @(posedge clock); while (!req_tready);
      tail_apply(cmd, din, has_rsp, ignored, rsp);
      if (has_rsp) expected_rsp.push_back(rsp);
      if (ignored) ignored_items++;
      else items_done++;
   endtask

   // Send a line body of random non-newline bytes, optionally terminated.
   task automatic send_text(int len, bit with_nl);
      logic [llrb_pkg::BYTE_W-1:0] ch;
      for (int i = 0; i < len; i++) begin
         do ch = llrb_pkg::BYTE_W'($urandom_range(0, 255)); while (ch == llrb_pkg::NEWLINE);
         send_item(llrb_pkg::CMD_BYTE, ch);
      end
      if (with_nl) send_item(llrb_pkg::CMD_BYTE, llrb_pkg::NEWLINE);
   endtask

   // Pull until the kept lines are read out, then a few pulls past the end.
   task automatic drain_lines(int extra);
      while (lines_due != 0)
         send_item(llrb_pkg::CMD_PULL, llrb_pkg::BYTE_W'($urandom_range(0, 255)));
      repeat (extra)
         send_item(llrb_pkg::CMD_PULL, llrb_pkg::BYTE_W'($urandom_range(0, 255)));
   endtask

   // Stop offering items and wait until every owed result has arrived.
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the line-count register while idle; this also empties the ring.
   task automatic write_kept(logic [llrb_pkg::KEPT_W-1:0] value);
      settle();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      kept_reg   = value;
      wr_slot    = 0;
      fill_len   = 0;
      line_total = 0;
      rd_slot    = 0;
      rd_pos     = 0;
      lines_due  = 0;
      draining   = 1'b0;
      config_writes++;
   endtask

   // Reset setting: pulls while collecting, stray codes, empty and open lines.
   task automatic test_defaults();
      send_item(llrb_pkg::CMD_PULL, 8'h00);
      send_item(CMD_NONE, 8'hFF);
      send_item(llrb_pkg::CMD_BYTE, llrb_pkg::NEWLINE);
      send_item(llrb_pkg::CMD_BYTE, 8'h00);
      send_item(llrb_pkg::CMD_BYTE, 8'hFF);
      send_item(llrb_pkg::CMD_BYTE, llrb_pkg::NEWLINE);
      send_item(llrb_pkg::CMD_BYTE, 8'h41);
      send_item(llrb_pkg::CMD_END, 8'h00);
      drain_lines(1);
      // Bytes and end items are dropped once the dump has started.
      send_item(llrb_pkg::CMD_BYTE, 8'h55);
      send_item(llrb_pkg::CMD_END, 8'hAA);
      send_item(llrb_pkg::CMD_PULL, 8'hFF);
   endtask

   // Out-of-range and small line counts, an empty dump and ring wraparound.
   task automatic test_kept_limits();
      write_kept(8'd0);
      send_text(2, 1'b1);
      send_text(3, 1'b1);
      send_item(llrb_pkg::CMD_END, 8'h00);
      drain_lines(1);
      write_kept(8'd255);
      send_item(llrb_pkg::CMD_END, 8'h00);
      send_item(llrb_pkg::CMD_PULL, 8'h00);
      write_kept(8'd129);
      send_text(1, 1'b1);
      send_text(0, 1'b1);
      send_item(llrb_pkg::CMD_END, 8'h00);
      drain_lines(0);
      write_kept(8'd3);
      repeat (5) send_text(1, 1'b1);
      send_item(llrb_pkg::CMD_END, 8'h00);
      drain_lines(1);
   endtask

   // A line that overruns the slot is split, and no byte is lost.
   task automatic test_long_line();
      write_kept(8'd3);
      send_text(llrb_pkg::LINE_BYTES + 1, 1'b0);
      send_item(llrb_pkg::CMD_END, 8'h00);
      drain_lines(1);
   endtask

   // Receiver holds off for a long stretch while pulls keep coming.
   task automatic test_backpressure();
      write_kept(8'd20);
      req_idle_on = 1'b0;
      repeat (20) send_text($urandom_range(0, 6), 1'b1);
      send_item(llrb_pkg::CMD_END, 8'h00);
      stall_asked++;
      drain_lines(2);
      settle();
      req_idle_on = 1'b1;
   endtask

   // One random setting: a line set, an end item and a full dump, with noise.
   task automatic run_tail_phase();
      logic [llrb_pkg::KEPT_W-1:0] kept_val;
      int                          cap;
      int                          nlines;
      int                          len;
      case ($urandom_range(0, 9))
         0:       kept_val = 8'd0;
         1:       kept_val = 8'd1;
         2:       kept_val = 8'd2;
         3:       kept_val = 8'd128;
         4:       kept_val = 8'd255;
         5, 6, 7: kept_val = llrb_pkg::KEPT_W'($urandom_range(1, 12));
         default: kept_val = llrb_pkg::KEPT_W'($urandom_range(0, 255));
      endcase
      write_kept(kept_val);
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
      cap = kept_lines() + 3;
      if (cap > 24) cap = 24;
      nlines = $urandom_range(0, cap);
      if ($urandom_range(0, 7) == 0)
         send_item(llrb_pkg::CMD_PULL, llrb_pkg::BYTE_W'($urandom_range(0, 255)));
      for (int i = 0; i < nlines; i++) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 12);
         send_text(len, (i != nlines - 1) || ($urandom_range(0, 1) == 1));
         if ($urandom_range(0, 19) == 0)
            send_item(CMD_NONE, llrb_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      // Occasionally the end item never comes and the pulls find nothing.
      if ($urandom_range(0, 9) == 0) begin
         drain_lines($urandom_range(1, 3));
      end else begin
         send_item(llrb_pkg::CMD_END, llrb_pkg::BYTE_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 5) == 0) begin
            send_item(($urandom_range(0, 1) == 1) ? llrb_pkg::CMD_BYTE : llrb_pkg::CMD_END,
                      llrb_pkg::BYTE_W'($urandom_range(0, 255)));
         end
         drain_lines($urandom_range(0, 3));
      end
   endtask

   task automatic test_random();
      int start;
      start = items_done;
      while (items_done - start < RANDOM_ITEMS) run_tail_phase();
   endtask

   // Result side: random wait per item, plus the long hold when asked for.
   always @(negedge clock) begin
      if (stall_asked != stall_done) begin
         stall_done = stall_asked;
         rsp_hold   = STALL_CYCLES;
      end
      if (results_seen != results_paced) begin
         results_paced = results_seen;
         rsp_wait      = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      tail_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
               $display("Unexpected item: data %h valid %b last %b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata !== want.char_out || rsp_tuser !== want.has_data ||
                rsp_tlast !== want.is_last) begin
               mismatches++;
               if (mismatches <= SHOWN_MISMATCHES)
                  $display("Result %0d: expected data %h valid %b last %b, got %h %b %b",
                           results_seen, want.char_out, want.has_data, want.is_last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_defaults();
      test_kept_limits();
      test_long_line();
      test_backpressure();
      test_random();
      settle();
      $display("Checked %0d pull results from %0d items (%0d dropped) over %0d line counts.",
               results_seen, items_done, ignored_items, config_writes);
      $display("Included empty, open and split lines, wraparound and a %0d-cycle stall.",
               STALL_CYCLES);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/llrb_pkg.sv
hdl/last_lines_ring_buffer.sv
verif/tb.sv
